// File: sv/mfm_pkg.sv
// ----------------------------------------------------------------------------
// mfm_pkg
// Shared types, register indexes, fault bit codes and opcodes for the motor
// fault monitor.
// ----------------------------------------------------------------------------
package mfm_pkg;

  localparam int unsigned AddrW   = 5;
  localparam int unsigned CfgIdxW = 3;
  localparam int unsigned FaultW  = 16;

  // register indexes
  localparam logic [CfgIdxW-1:0] REG_BUS_UV     = 3'd0;
  localparam logic [CfgIdxW-1:0] REG_BUS_OV     = 3'd1;
  localparam logic [CfgIdxW-1:0] REG_OVERCUR    = 3'd2;
  localparam logic [CfgIdxW-1:0] REG_TEMP       = 3'd3;
  localparam logic [CfgIdxW-1:0] REG_SPEED      = 3'd4;
  localparam logic [CfgIdxW-1:0] REG_MIN_AVG    = 3'd5;
  localparam logic [CfgIdxW-1:0] REG_LOSS_RATIO = 3'd6;
  localparam logic [CfgIdxW-1:0] REG_WARN_RATIO = 3'd7;

  // fault bit codes
  localparam logic [FaultW-1:0] FLT_BUS_UV     = 16'h0001;
  localparam logic [FaultW-1:0] FLT_BUS_OV     = 16'h0002;
  localparam logic [FaultW-1:0] FLT_OVERCUR    = 16'h0004;
  localparam logic [FaultW-1:0] FLT_OVERTEMP   = 16'h0008;
  localparam logic [FaultW-1:0] FLT_OVERSPEED  = 16'h0010;
  localparam logic [FaultW-1:0] FLT_PHASE_LOSS = 16'h0020;
  localparam logic [FaultW-1:0] FLT_IMBALANCE  = 16'h0040;
  localparam logic [FaultW-1:0] FLT_POLL_MASK  = 16'h007F;

  typedef enum logic [1:0] {
    OP_POLL        = 2'd0,
    OP_RAISE       = 2'd1,
    OP_CLR_STATUS  = 2'd2,
    OP_CLR_LATCHED = 2'd3
  } mfm_op_e;

  typedef struct packed {
    logic [15:0] bus_uv;
    logic [15:0] bus_ov;
    logic [15:0] overcur;
    logic [14:0] temp;
    logic [15:0] speed;
    logic [15:0] min_avg;
    logic [15:0] loss_ratio;
    logic [15:0] warn_ratio;
  } mfm_cfg_t;

endpackage

// File: sv/mfm_regs.sv
// ----------------------------------------------------------------------------
// mfm_regs
// APB-style configuration register file holding the fault thresholds.
// ----------------------------------------------------------------------------
module mfm_regs (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [mfm_pkg::AddrW-1:0]  paddr,
  input  logic [31:0]                pwdata,
  output logic [31:0]                prdata,
  output logic                       pready,
  output mfm_pkg::mfm_cfg_t          cfg_o
);
  import mfm_pkg::*;

  mfm_cfg_t           cfg_q;
  logic [CfgIdxW-1:0] idx;
  logic               wr_en;

  assign idx    = paddr[AddrW-1:2];
  assign wr_en  = psel & penable & pwrite;
  assign pready = 1'b1;
  assign cfg_o  = cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else if (wr_en) begin
      case (idx)
        REG_BUS_UV:     cfg_q.bus_uv     <= pwdata[15:0];
        REG_BUS_OV:     cfg_q.bus_ov     <= pwdata[15:0];
        REG_OVERCUR:    cfg_q.overcur    <= pwdata[15:0];
        REG_TEMP:       cfg_q.temp       <= pwdata[14:0];
        REG_SPEED:      cfg_q.speed      <= pwdata[15:0];
        REG_MIN_AVG:    cfg_q.min_avg    <= pwdata[15:0];
        REG_LOSS_RATIO: cfg_q.loss_ratio <= pwdata[15:0];
        REG_WARN_RATIO: cfg_q.warn_ratio <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      REG_BUS_UV:     prdata = {16'd0, cfg_q.bus_uv};
      REG_BUS_OV:     prdata = {16'd0, cfg_q.bus_ov};
      REG_OVERCUR:    prdata = {16'd0, cfg_q.overcur};
      REG_TEMP:       prdata = {17'd0, cfg_q.temp};
      REG_SPEED:      prdata = {16'd0, cfg_q.speed};
      REG_MIN_AVG:    prdata = {16'd0, cfg_q.min_avg};
      REG_LOSS_RATIO: prdata = {16'd0, cfg_q.loss_ratio};
      REG_WARN_RATIO: prdata = {16'd0, cfg_q.warn_ratio};
      default:        prdata = '0;
    endcase
  end

endmodule

// File: sv/mfm_check.sv
// ----------------------------------------------------------------------------
// mfm_check
// Threshold checks of one measurement sample, giving the poll-owned fault bits.
// ----------------------------------------------------------------------------
module mfm_check (
  input  mfm_pkg::mfm_cfg_t          cfg_i,
  input  logic [15:0]                bus_voltage_i,
  input  logic signed [15:0]         current_a_i,
  input  logic signed [15:0]         current_b_i,
  input  logic signed [15:0]         current_c_i,
  input  logic signed [15:0]         motor_temperature_i,
  input  logic signed [15:0]         rotor_speed_i,
  output logic [mfm_pkg::FaultW-1:0] poll_faults_o
);
  import mfm_pkg::*;

  // magnitude of a 16-bit signed value, -32768 gives 32768
  function automatic logic [16:0] mag16(logic signed [15:0] v);
    logic [16:0] ext;
    ext = {v[15], v};
    return v[15] ? 17'(~ext + 17'd1) : ext;
  endfunction

  logic [16:0] abs_a, abs_b, abs_c, abs_spd;
  logic [16:0] mx_ab, mn_ab, mx, mn, diff;
  logic [17:0] sum, min_sum;
  logic [26:0] lhs;
  logic [33:0] loss_rhs, warn_rhs;
  logic        imb_en, loss_hit, warn_hit;

  always_comb begin
    abs_a   = mag16(current_a_i);
    abs_b   = mag16(current_b_i);
    abs_c   = mag16(current_c_i);
    abs_spd = mag16(rotor_speed_i);

    mx_ab = (abs_a > abs_b) ? abs_a : abs_b;
    mn_ab = (abs_a < abs_b) ? abs_a : abs_b;
    mx    = (mx_ab > abs_c) ? mx_ab : abs_c;
    mn    = (mn_ab < abs_c) ? mn_ab : abs_c;
    diff  = mx - mn;
    sum   = 18'(abs_a) + 18'(abs_b) + 18'(abs_c);

    // 3 * min_average and 768 * (max - min) as shift-adds
    min_sum  = {1'b0, cfg_i.min_avg, 1'b0} + 18'(cfg_i.min_avg);
    lhs      = {1'b0, diff, 9'd0} + {2'b00, diff, 8'd0};
    loss_rhs = 34'(cfg_i.loss_ratio) * 34'(sum);
    warn_rhs = 34'(cfg_i.warn_ratio) * 34'(sum);

    imb_en   = (cfg_i.min_avg != '0) &&
               ((cfg_i.loss_ratio != '0) || (cfg_i.warn_ratio != '0)) &&
               (sum > min_sum);
    loss_hit = imb_en && (cfg_i.loss_ratio != '0) && (34'(lhs) > loss_rhs);
    warn_hit = imb_en && !loss_hit && (cfg_i.warn_ratio != '0) &&
               (34'(lhs) > warn_rhs);

    poll_faults_o = '0;
    if ((cfg_i.bus_uv != '0) && (bus_voltage_i != '0) && (bus_voltage_i < cfg_i.bus_uv))
      poll_faults_o = poll_faults_o | FLT_BUS_UV;
    if ((cfg_i.bus_ov != '0) && (bus_voltage_i > cfg_i.bus_ov))
      poll_faults_o = poll_faults_o | FLT_BUS_OV;
    if ((cfg_i.overcur != '0) && (mx > {1'b0, cfg_i.overcur}))
      poll_faults_o = poll_faults_o | FLT_OVERCUR;
    if ((cfg_i.temp != '0) && (motor_temperature_i > $signed({1'b0, cfg_i.temp})))
      poll_faults_o = poll_faults_o | FLT_OVERTEMP;
    if ((cfg_i.speed != '0) && (abs_spd > {1'b0, cfg_i.speed}))
      poll_faults_o = poll_faults_o | FLT_OVERSPEED;
    if (loss_hit)
      poll_faults_o = poll_faults_o | FLT_PHASE_LOSS;
    if (warn_hit)
      poll_faults_o = poll_faults_o | FLT_IMBALANCE;
  end

endmodule

// File: sv/motor_fault_monitor.sv
// ----------------------------------------------------------------------------
// motor_fault_monitor
// Motor fault supervisor: live status word and sticky latched fault word.
//
// Each input transaction carries an opcode: poll one measurement sample,
// raise external fault bits, clear status bits under a mask, or clear latched
// and status bits under a mask. A poll clears the seven poll-owned status
// bits (0..6) and then sets undervoltage, overvoltage, overcurrent,
// overtemperature, overspeed, phase loss or imbalance warning as the
// thresholds dictate; a zero threshold disables its check. Every raised bit
// is set in both words. Each transaction gives exactly one result carrying
// both words after the update and pwm_off, high when a poll leaves any
// latched fault. The block takes one transaction per clock cycle while the
// result side does not stall; an accepted transaction loads the input
// register, and the check logic and state update then load the result
// register. Back-pressure on the result side stalls both stages.
// Thresholds are written over the APB-style port at byte address 4*index
// and should only change while no transaction is in flight.
// ----------------------------------------------------------------------------
module motor_fault_monitor (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  // configuration port
  input  logic                      psel,
  input  logic                      penable,
  input  logic                      pwrite,
  input  logic [mfm_pkg::AddrW-1:0] paddr,
  input  logic [31:0]               pwdata,
  output logic [31:0]               prdata,
  output logic                      pready,
  // input channel
  input  logic                      in_valid_i,
  output logic                      in_ready_o,
  input  logic [1:0]                opcode_i,
  input  logic [15:0]               bus_voltage_i,
  input  logic signed [15:0]        current_a_i,
  input  logic signed [15:0]        current_b_i,
  input  logic signed [15:0]        current_c_i,
  input  logic signed [15:0]        motor_temperature_i,
  input  logic signed [15:0]        rotor_speed_i,
  input  logic [15:0]               fault_bits_i,
  // result channel
  output logic                      out_valid_o,
  input  logic                      out_ready_i,
  output logic [15:0]               status_word_o,
  output logic [15:0]               latched_word_o,
  output logic                      pwm_off_o
);
  import mfm_pkg::*;

  mfm_cfg_t cfg;

  // input register stage
  logic               in_valid_q, in_valid_d;
  mfm_op_e            opcode_q;
  logic [15:0]        bus_voltage_q;
  logic signed [15:0] current_a_q, current_b_q, current_c_q;
  logic signed [15:0] motor_temperature_q, rotor_speed_q;
  logic [15:0]        fault_bits_q;

  // fault state
  logic [FaultW-1:0] live_q, live_d, sticky_q, sticky_d;

  // result register stage
  logic              out_valid_q, out_valid_d;
  logic [FaultW-1:0] status_q, latched_q;
  logic              pwm_off_q, pwm_off_d;

  logic [FaultW-1:0] poll_faults;
  logic              advance, fire, in_take;

  mfm_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  mfm_check u_check (
    .cfg_i               (cfg),
    .bus_voltage_i       (bus_voltage_q),
    .current_a_i         (current_a_q),
    .current_b_i         (current_b_q),
    .current_c_i         (current_c_q),
    .motor_temperature_i (motor_temperature_q),
    .rotor_speed_i       (rotor_speed_q),
    .poll_faults_o       (poll_faults)
  );

  // result slot frees up when empty or being taken this cycle
  assign advance    = !out_valid_q || out_ready_i;
  assign fire       = in_valid_q && advance;
  assign in_ready_o = !in_valid_q || advance;
  assign in_take    = in_valid_i && in_ready_o;

  assign in_valid_d  = in_ready_o ? in_valid_i : in_valid_q;
  assign out_valid_d = advance ? in_valid_q : out_valid_q;

  // state update for the transaction leaving the input register
  always_comb begin
    live_d    = live_q;
    sticky_d  = sticky_q;
    pwm_off_d = 1'b0;
    case (opcode_q)
      OP_POLL: begin
        live_d    = (live_q & ~FLT_POLL_MASK) | poll_faults;
        sticky_d  = sticky_q | poll_faults;
        pwm_off_d = (sticky_d != '0);
      end
      OP_RAISE: begin
        live_d   = live_q | fault_bits_q;
        sticky_d = sticky_q | fault_bits_q;
      end
      OP_CLR_STATUS: begin
        live_d = live_q & ~fault_bits_q;
      end
      OP_CLR_LATCHED: begin
        live_d   = live_q & ~fault_bits_q;
        sticky_d = sticky_q & ~fault_bits_q;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      live_q      <= '0;
      sticky_q    <= '0;
    end else begin
      in_valid_q  <= in_valid_d;
      out_valid_q <= out_valid_d;
      if (fire) begin
        live_q   <= live_d;
        sticky_q <= sticky_d;
      end
    end
  end

  // payload registers, no reset
  always_ff @(posedge clk_i) begin
    if (in_take) begin
      opcode_q            <= mfm_op_e'(opcode_i);
      bus_voltage_q       <= bus_voltage_i;
      current_a_q         <= current_a_i;
      current_b_q         <= current_b_i;
      current_c_q         <= current_c_i;
      motor_temperature_q <= motor_temperature_i;
      rotor_speed_q       <= rotor_speed_i;
      fault_bits_q        <= fault_bits_i;
    end
    if (fire) begin
      status_q  <= live_d;
      latched_q <= sticky_d;
      pwm_off_q <= pwm_off_d;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign status_word_o  = status_q;
  assign latched_word_o = latched_q;
  assign pwm_off_o      = pwm_off_q;

`ifndef SYNTHESIS
  // every live bit is also latched
  a_live_in_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (live_q & ~sticky_q) == '0)
    else $error("live fault bit set without latched bit");

  // a finished transaction shows the updated state in the result register
  a_result_matches_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire |=> out_valid_q && (status_word_o == live_q) && (latched_word_o == sticky_q))
    else $error("result does not match fault state");

  // only a poll can switch the pwm off
  a_pwm_off_poll_only: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fire && (opcode_q != OP_POLL)) |=> !pwm_off_q)
    else $error("pwm_off raised by a non-poll transaction");

  // pwm off needs a latched fault
  a_pwm_off_latched: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && pwm_off_o) |-> (latched_word_o != '0))
    else $error("pwm_off without latched fault");

  // fault state moves only with a transaction
  a_state_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !fire |=> $stable(live_q) && $stable(sticky_q))
    else $error("fault state changed without a transaction");
`endif

endmodule

// File: dv/motor_fault_monitor_tb.sv
// ----------------------------------------------------------------------------
// motor_fault_monitor_tb
// Self-checking testbench for the motor fault supervisor. A tracker class
// predicts the live and latched fault words for every accepted command and
// compares them with each result in order. Limits are programmed over the
// APB port and read back between phases. Directed commands cover the
// threshold edges first, then random traffic runs under several limit sets.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module motor_fault_monitor_tb;
  import mfm_pkg::*;

  localparam int unsigned RunLimitNs  = 10_000_000;
  localparam int unsigned RandBlocks  = 10;
  localparam int unsigned BlockLength = 65;

  // one command as presented on the input channel
  typedef struct {
    mfm_op_e            opcode;
    logic [15:0]        bus_voltage;
    logic signed [15:0] current_a;
    logic signed [15:0] current_b;
    logic signed [15:0] current_c;
    logic signed [15:0] motor_temperature;
    logic signed [15:0] rotor_speed;
    logic [15:0]        fault_bits;
  } motor_cmd_t;

  // fault words expected back for one command
  typedef struct {
    logic [15:0] status_word;
    logic [15:0] latched_word;
    logic        pwm_off;
  } fault_report_t;

  // tracks the limits and both fault words, and checks results in order
  class fault_word_tracker;
    mfm_cfg_t      cfg;
    logic [15:0]   live;
    logic [15:0]   sticky;
    fault_report_t reports_due[$];
    int unsigned   failures;
    int unsigned   checked;
    int unsigned   op_count[4];

    function new();
      cfg      = '0;
      live     = '0;
      sticky   = '0;
      failures = 0;
      checked  = 0;
      foreach (op_count[i]) op_count[i] = 0;
    endfunction

    function void set_reg(logic [CfgIdxW-1:0] idx, logic [31:0] value);
      case (idx)
        REG_BUS_UV:     cfg.bus_uv     = value[15:0];
        REG_BUS_OV:     cfg.bus_ov     = value[15:0];
        REG_OVERCUR:    cfg.overcur    = value[15:0];
        REG_TEMP:       cfg.temp       = value[14:0];
        REG_SPEED:      cfg.speed      = value[15:0];
        REG_MIN_AVG:    cfg.min_avg    = value[15:0];
        REG_LOSS_RATIO: cfg.loss_ratio = value[15:0];
        default:        cfg.warn_ratio = value[15:0];
      endcase
    endfunction

    function logic [31:0] reg_value(logic [CfgIdxW-1:0] idx);
      case (idx)
        REG_BUS_UV:     return 32'(cfg.bus_uv);
        REG_BUS_OV:     return 32'(cfg.bus_ov);
        REG_OVERCUR:    return 32'(cfg.overcur);
        REG_TEMP:       return 32'(cfg.temp);
        REG_SPEED:      return 32'(cfg.speed);
        REG_MIN_AVG:    return 32'(cfg.min_avg);
        REG_LOSS_RATIO: return 32'(cfg.loss_ratio);
        default:        return 32'(cfg.warn_ratio);
      endcase
    endfunction

    function logic [15:0] magnitude(logic signed [15:0] v);
      // -32768 maps to 16'h8000, read as unsigned
      return v[15] ? (~v + 16'd1) : v;
    endfunction

    function void raise(logic [15:0] bits);
      live   |= bits;
      sticky |= bits;
    endfunction

    function void note_command(motor_cmd_t c);
      logic [15:0]   m0, m1, m2, mx, mn, spd;
      logic [17:0]   sum;
      logic [33:0]   spread;
      fault_report_t r;
      r.pwm_off = 1'b0;
      op_count[c.opcode]++;
      case (c.opcode)
        OP_POLL: begin
          live &= ~FLT_POLL_MASK;
          m0  = magnitude(c.current_a);
          m1  = magnitude(c.current_b);
          m2  = magnitude(c.current_c);
          spd = magnitude(c.rotor_speed);
          if (cfg.bus_uv != 0 && c.bus_voltage != 0 && c.bus_voltage < cfg.bus_uv) begin
            raise(FLT_BUS_UV);
          end
          if (cfg.bus_ov != 0 && c.bus_voltage > cfg.bus_ov) begin
            raise(FLT_BUS_OV);
          end
          mx  = (m0 > m1) ? m0 : m1;
          mx  = (mx > m2) ? mx : m2;
          mn  = (m0 < m1) ? m0 : m1;
          mn  = (mn < m2) ? mn : m2;
          sum = 18'(m0) + 18'(m1) + 18'(m2);
          if (cfg.overcur != 0 && mx > cfg.overcur) begin
            raise(FLT_OVERCUR);
          end
          if (cfg.temp != 0 && int'(c.motor_temperature) > int'(cfg.temp)) begin
            raise(FLT_OVERTEMP);
          end
          if (cfg.speed != 0 && spd > cfg.speed) begin
            raise(FLT_OVERSPEED);
          end
          // imbalance judged only above the minimum average; loss wins over warning
          if (cfg.min_avg != 0 && (cfg.loss_ratio != 0 || cfg.warn_ratio != 0) &&
              sum > 18'(cfg.min_avg) * 18'd3) begin
            spread = 34'(mx - mn) * 34'd768;
            if (cfg.loss_ratio != 0 && spread > 34'(cfg.loss_ratio) * 34'(sum)) begin
              raise(FLT_PHASE_LOSS);
            end else if (cfg.warn_ratio != 0 &&
                         spread > 34'(cfg.warn_ratio) * 34'(sum)) begin
              raise(FLT_IMBALANCE);
            end
          end
          r.pwm_off = (sticky != 0);
        end
        OP_RAISE: begin
          raise(c.fault_bits);
        end
        OP_CLR_STATUS: begin
          live &= ~c.fault_bits;
        end
        default: begin
          sticky &= ~c.fault_bits;
          live   &= ~c.fault_bits;
        end
      endcase
      r.status_word  = live;
      r.latched_word = sticky;
      reports_due.push_back(r);
    endfunction

    function void check_report(logic [15:0] status_word, logic [15:0] latched_word,
                               logic pwm_off);
      fault_report_t r;
      if (reports_due.size() == 0) begin
        $error("result with no command pending: status %h latched %h pwm_off %b",
               status_word, latched_word, pwm_off);
        failures++;
        return;
      end
      r = reports_due.pop_front();
      checked++;
      if (status_word !== r.status_word) begin
        $error("status_word: expected %h, actual %h", r.status_word, status_word);
        failures++;
      end
      if (latched_word !== r.latched_word) begin
        $error("latched_word: expected %h, actual %h", r.latched_word, latched_word);
        failures++;
      end
      if (pwm_off !== r.pwm_off) begin
        $error("pwm_off: expected %b, actual %b", r.pwm_off, pwm_off);
        failures++;
      end
    endfunction

    function int unsigned pending();
      return reports_due.size();
    endfunction
  endclass

  // clock, reset and block signals; everything starts at a known value
  logic               clk       = 1'b0;
  logic               rst_n     = 1'b0;
  logic               psel      = 1'b0;
  logic               penable   = 1'b0;
  logic               pwrite    = 1'b0;
  logic [AddrW-1:0]   paddr     = '0;
  logic [31:0]        pwdata    = '0;
  logic [31:0]        prdata;
  logic               pready;
  logic               in_valid  = 1'b0;
  logic               in_ready;
  logic [1:0]         opcode    = '0;
  logic [15:0]        bus_voltage = '0;
  logic signed [15:0] current_a = '0;
  logic signed [15:0] current_b = '0;
  logic signed [15:0] current_c = '0;
  logic signed [15:0] motor_temperature = '0;
  logic signed [15:0] rotor_speed = '0;
  logic [15:0]        fault_bits = '0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  logic [15:0]        status_word;
  logic [15:0]        latched_word;
  logic               pwm_off;

  // idling on both channels is switched off for the closing stretch
  bit                 idle_on   = 1'b1;
  int unsigned        settings_applied = 0;

  fault_word_tracker  tracker = new();

  always #10 clk = ~clk;

  motor_fault_monitor dut (
    .clk_i               (clk),
    .rst_ni              (rst_n),
    .psel                (psel),
    .penable             (penable),
    .pwrite              (pwrite),
    .paddr               (paddr),
    .pwdata              (pwdata),
    .prdata              (prdata),
    .pready              (pready),
    .in_valid_i          (in_valid),
    .in_ready_o          (in_ready),
    .opcode_i            (opcode),
    .bus_voltage_i       (bus_voltage),
    .current_a_i         (current_a),
    .current_b_i         (current_b),
    .current_c_i         (current_c),
    .motor_temperature_i (motor_temperature),
    .rotor_speed_i       (rotor_speed),
    .fault_bits_i        (fault_bits),
    .out_valid_o         (out_valid),
    .out_ready_i         (out_ready),
    .status_word_o       (status_word),
    .latched_word_o      (latched_word),
    .pwm_off_o           (pwm_off)
  );

  // apb write: setup cycle, access cycle, then back to idle so that
  // back-to-back calls never assign psel twice in one step
  task automatic apb_write(logic [CfgIdxW-1:0] idx, logic [31:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= AddrW'({idx, 2'b00});
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    tracker.set_reg(idx, value);
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  // apb read, compared with the masked value the tracker holds
  task automatic apb_read_check(logic [CfgIdxW-1:0] idx);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= AddrW'({idx, 2'b00});
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (prdata !== tracker.reg_value(idx)) begin
      $error("prdata reg %0d: expected %h, actual %h", idx, tracker.reg_value(idx), prdata);
      tracker.failures++;
    end
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  // sender: optional gap, then hold the transaction until it is accepted
  task automatic send_cmd(motor_cmd_t c);
    if (idle_on && $urandom_range(0, 4) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
    end
    in_valid          <= 1'b1;
    opcode            <= c.opcode;
    bus_voltage       <= c.bus_voltage;
    current_a         <= c.current_a;
    current_b         <= c.current_b;
    current_c         <= c.current_c;
    motor_temperature <= c.motor_temperature;
    rotor_speed       <= c.rotor_speed;
    fault_bits        <= c.fault_bits;
    do @(posedge clk); while (!in_ready);
    tracker.note_command(c);
  endtask

  // stop sending and wait until every expected result is back
  task automatic wait_drained();
    in_valid <= 1'b0;
    while (tracker.pending() != 0) @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  // program all eight limits; mode 0 mixes zero, top and working values, mode 1
  // sets top (32768 overcur/speed/min_avg, else max); random junk above the width
  task automatic program_limits(int unsigned mode);
    logic [31:0] v;
    int unsigned w, top, pick;
    for (int i = 0; i < 8; i++) begin
      w    = (CfgIdxW'(i) == REG_TEMP) ? 15 : 16;
      case (CfgIdxW'(i))
        REG_OVERCUR, REG_SPEED, REG_MIN_AVG: top = 32768;
        REG_TEMP:                            top = 32767;
        default:                             top = 65535;
      endcase
      pick = (mode == 1) ? 1 : $urandom_range(0, 7);
      case (pick)
        0: v = 0;
        1: v = top;
        default: begin
          case (CfgIdxW'(i))
            REG_BUS_UV:     v = $urandom_range(1, 40000);
            REG_BUS_OV:     v = $urandom_range(20000, 65535);
            REG_MIN_AVG:    v = $urandom_range(1, 3000);
            REG_LOSS_RATIO: v = $urandom_range(32, 1024);
            REG_WARN_RATIO: v = $urandom_range(8, 512);
            default:        v = $urandom_range(1, top);
          endcase
        end
      endcase
      if ($urandom_range(0, 1)) v |= ($urandom << w);
      apb_write(CfgIdxW'(i), v);
    end
    for (int i = 0; i < 8; i++) apb_read_check(CfgIdxW'(i));
    settings_applied++;
  endtask

  function automatic motor_cmd_t quiet_poll();
    motor_cmd_t c;
    c.opcode            = OP_POLL;
    c.bus_voltage       = 16'd30000;
    c.current_a         = '0;
    c.current_b         = '0;
    c.current_c         = '0;
    c.motor_temperature = '0;
    c.rotor_speed       = '0;
    c.fault_bits        = '0;
    return c;
  endfunction

  function automatic motor_cmd_t bit_cmd(mfm_op_e op, logic [15:0] bits);
    motor_cmd_t c;
    c            = quiet_poll();
    c.opcode     = op;
    c.fault_bits = bits;
    return c;
  endfunction

  function automatic logic [15:0] near16(logic [15:0] lim);
    return lim + 16'($urandom_range(0, 4)) - 16'd2;
  endfunction

  // raw random, an extreme, or a value straddling the given limit
  function automatic logic [15:0] pick16(logic [15:0] lim);
    case ($urandom_range(0, 5))
      0, 1: return 16'($urandom);
      2: begin
        case ($urandom_range(0, 4))
          0:       return 16'h0000;
          1:       return 16'h0001;
          2:       return 16'h7FFF;
          3:       return 16'h8000;
          default: return 16'hFFFF;
        endcase
      end
      3, 4:    return near16(lim);
      default: return 16'h0 - near16(lim);
    endcase
  endfunction

  // phase current at or below a peak, random sign
  function automatic logic [15:0] phase_near(int unsigned peak);
    logic [15:0] v;
    if ($urandom_range(0, 2) == 0) v = 16'(peak);
    else v = 16'((peak * $urandom_range(0, 256)) / 256);
    return $urandom_range(0, 1) ? (16'h0 - v) : v;
  endfunction

  function automatic motor_cmd_t random_cmd();
    motor_cmd_t  c;
    int unsigned sel, cap;
    sel = $urandom_range(0, 99);
    if (sel < 60)      c.opcode = OP_POLL;
    else if (sel < 75) c.opcode = OP_RAISE;
    else if (sel < 87) c.opcode = OP_CLR_STATUS;
    else               c.opcode = OP_CLR_LATCHED;
    c.bus_voltage = pick16($urandom_range(0, 1) ? tracker.cfg.bus_uv : tracker.cfg.bus_ov);
    if ($urandom_range(0, 1)) begin
      // shaped around the imbalance window
      cap = 4 * tracker.cfg.min_avg + 64;
      if (cap > 32767) cap = 32767;
      cap = $urandom_range(0, cap);
      c.current_a = phase_near(cap);
      c.current_b = phase_near(cap);
      c.current_c = phase_near(cap);
    end else begin
      c.current_a = pick16(tracker.cfg.overcur);
      c.current_b = pick16(tracker.cfg.overcur);
      c.current_c = pick16(tracker.cfg.overcur);
    end
    c.motor_temperature = pick16({1'b0, tracker.cfg.temp});
    c.rotor_speed       = pick16(tracker.cfg.speed);
    case ($urandom_range(0, 3))
      0:       c.fault_bits = 16'($urandom);
      1:       c.fault_bits = 16'h0001 << $urandom_range(0, 15);
      2:       c.fault_bits = 16'h0000;
      default: c.fault_bits = 16'hFFFF;
    endcase
    return c;
  endfunction

  // result side: check every accepted result, stall in random bursts
  initial begin : result_sink
    int unsigned stall_left;
    stall_left = 0;
    @(posedge rst_n);
    forever begin
      @(posedge clk);
      if (out_valid && out_ready) begin
        tracker.check_report(status_word, latched_word, pwm_off);
      end
      if (stall_left != 0) begin
        stall_left--;
        out_ready <= 1'b0;
      end else if (idle_on && $urandom_range(0, 5) == 0) begin
        stall_left = $urandom_range(0, 7);
        out_ready  <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  initial begin : stimulus
    motor_cmd_t  c;
    int unsigned drain_at;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // limits read back as zero after reset
    for (int i = 0; i < 8; i++) apb_read_check(CfgIdxW'(i));

    // all checks disabled: extreme samples raise nothing
    c = quiet_poll();
    c.bus_voltage       = 16'hFFFF;
    c.current_a         = -16'sd32768;
    c.current_b         = 16'sd32767;
    c.current_c         = -16'sd32768;
    c.motor_temperature = 16'sd32767;
    c.rotor_speed       = -16'sd32768;
    send_cmd(c);
    // raising no bits leaves both words alone
    send_cmd(bit_cmd(OP_RAISE, 16'h0000));
    send_cmd(bit_cmd(OP_RAISE, 16'hFF80));
    c = quiet_poll();
    c.bus_voltage = 16'h0000;
    send_cmd(c);
    send_cmd(bit_cmd(OP_CLR_STATUS, 16'hFFFF));
    send_cmd(bit_cmd(OP_CLR_LATCHED, 16'hFFFF));
    wait_drained();

    // working limits, some with junk above the register width
    apb_write(REG_BUS_UV,     32'hABCD_03E8);
    apb_write(REG_BUS_OV,     32'd60000);
    apb_write(REG_OVERCUR,    32'd20000);
    apb_write(REG_TEMP,       32'hFFFF_8064);
    apb_write(REG_SPEED,      32'd30000);
    apb_write(REG_MIN_AVG,    32'd100);
    apb_write(REG_LOSS_RATIO, 32'h0001_0100);
    apb_write(REG_WARN_RATIO, 32'd64);
    for (int i = 0; i < 8; i++) apb_read_check(CfgIdxW'(i));
    settings_applied++;

    // zero bus voltage is not an undervoltage
    c = quiet_poll(); c.bus_voltage = 16'd0;        send_cmd(c);
    c = quiet_poll(); c.bus_voltage = 16'd999;      send_cmd(c);
    c = quiet_poll(); c.bus_voltage = 16'd1000;     send_cmd(c);
    c = quiet_poll(); c.bus_voltage = 16'd60001;    send_cmd(c);
    c = quiet_poll(); c.current_a = -16'sd20001;    send_cmd(c);
    c = quiet_poll(); c.motor_temperature = 16'sd101;     send_cmd(c);
    c = quiet_poll(); c.motor_temperature = -16'sd32768;  send_cmd(c);
    c = quiet_poll(); c.rotor_speed = -16'sd30001;  send_cmd(c);
    // phase loss, then the warning band, then below the minimum average
    c = quiet_poll();
    c.current_a = 16'sd1000; c.current_b = 16'sd1000; c.current_c = 16'sd0;
    send_cmd(c);
    c = quiet_poll();
    c.current_a = 16'sd1000; c.current_b = -16'sd1000; c.current_c = 16'sd700;
    send_cmd(c);
    c = quiet_poll();
    c.current_a = 16'sd100; c.current_b = 16'sd100; c.current_c = 16'sd0;
    send_cmd(c);
    // an externally raised poll bit is dropped from status by the next poll
    send_cmd(bit_cmd(OP_RAISE, FLT_BUS_UV));
    send_cmd(quiet_poll());
    send_cmd(bit_cmd(OP_CLR_LATCHED, 16'h00FF));
    wait_drained();

    // every limit at its maximum
    program_limits(1);
    c = quiet_poll();
    c.current_a = -16'sd32768; c.current_b = -16'sd32768;
    c.motor_temperature = 16'sd32767; c.rotor_speed = -16'sd32768;
    send_cmd(c);
    c = quiet_poll(); c.bus_voltage = 16'hFFFE; send_cmd(c);
    wait_drained();

    // random traffic, a new limit set per block
    for (int b = 0; b < RandBlocks; b++) begin
      program_limits(0);
      if (b == RandBlocks - 1) idle_on = 1'b0;
      drain_at = $urandom_range(10, BlockLength - 10);
      for (int k = 0; k < BlockLength; k++) begin
        // sender holds off mid-block until the pipeline is empty
        if (k == drain_at && idle_on) wait_drained();
        send_cmd(random_cmd());
      end
      wait_drained();
    end

    in_valid <= 1'b0;
    while (tracker.pending() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (tracker.pending() != 0) begin
      $error("%0d results never arrived", tracker.pending());
    end
    $display("covered %0d polls, %0d raises, %0d status clears, %0d latched clears",
             tracker.op_count[OP_POLL], tracker.op_count[OP_RAISE],
             tracker.op_count[OP_CLR_STATUS], tracker.op_count[OP_CLR_LATCHED]);
    $display("%0d results checked under %0d limit sets", tracker.checked, settings_applied);
    if (tracker.failures == 0 && tracker.pending() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  // hard stop far beyond the slowest correct run
  initial begin : watchdog
    #(RunLimitNs);
    $display("*** FAILED ***");
    $finish;
  end

endmodule
